// File: rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg: shared types and constants for the binomial smoothing filter
// Sample and result payloads, partial sum types and the 1-2-1 helper.
// ----------------------------------------------------------------------------
package bas_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int HSUM_W        = SAMPLE_W + 2;
   localparam int VSUM_W        = SAMPLE_W + 4;
   localparam int COL_OUT_W     = 6;
   localparam int ROW_OUT_W     = 5;
   localparam int DEF_TILE_COLS = 64;
   localparam int DEF_TILE_ROWS = 32;
   localparam int AXIS_SHIFT    = 3;
   localparam int BODY_SHIFT    = 4;

   typedef logic signed [SAMPLE_W-1:0] bas_sample_type;
   typedef logic signed [HSUM_W-1:0]   bas_hsum_type;
   typedef logic signed [VSUM_W-1:0]   bas_vsum_type;

   typedef struct packed {
      bas_sample_type sample_re;
      bas_sample_type sample_im;
      logic           tile_end;
   } bas_req_type;

   typedef struct packed {
      bas_sample_type        smooth_re;
      bas_sample_type        smooth_im;
      logic [COL_OUT_W-1:0]  cell_col;
      logic [ROW_OUT_W-1:0]  cell_row;
      logic                  tile_done;
   } bas_rsp_type;

   typedef struct packed {
      bas_sample_type re;
      bas_sample_type im;
   } bas_pair_type;

   typedef struct packed {
      bas_hsum_type re;
      bas_hsum_type im;
   } bas_hpair_type;

   // one request's partial sums and tags, handed to the output pipeline
   typedef struct packed {
      bas_hpair_type         h_far;
      bas_hpair_type         h_near;
      bas_hpair_type         h_cur;
      bas_sample_type        centre_im;
      logic                  axis;
      logic                  mode_zero;
      logic [COL_OUT_W-1:0]  col;
      logic [ROW_OUT_W-1:0]  row;
      logic                  done;
   } bas_stage_type;

   function automatic bas_hsum_type hsum(bas_sample_type l, bas_sample_type c,
                                         bas_sample_type r);
      bas_hsum_type cw;
      cw = HSUM_W'(c);
      return HSUM_W'(l) + (cw <<< 1) + HSUM_W'(r);
   endfunction

endpackage

// File: rtl/bas_cell.sv
// ----------------------------------------------------------------------------
// bas_cell: one column of the two line stores
// Holds the near and far row sample of one column and passes both on.
// ----------------------------------------------------------------------------
module bas_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  bas_pkg::bas_pair_type near_in,
   input  bas_pkg::bas_pair_type far_in,
   output bas_pkg::bas_pair_type near_out,
   output bas_pkg::bas_pair_type far_out
);
   import bas_pkg::*;

   bas_pair_type near_ff;
   bas_pair_type far_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   assign near_out = near_ff;
   assign far_out  = far_ff;

endmodule

// File: rtl/bas_window.sv
// ----------------------------------------------------------------------------
// bas_window: 3x2 sample window and horizontal 1-2-1 sums
// Keeps the two previous columns of the far, near and current rows.
// ----------------------------------------------------------------------------
module bas_window (
   input  logic                   clock,
   input  logic                   shift_en,
   input  bas_pkg::bas_pair_type  cur,
   input  bas_pkg::bas_pair_type  near_tap,
   input  bas_pkg::bas_pair_type  far_tap,
   output bas_pkg::bas_hpair_type h_far,
   output bas_pkg::bas_hpair_type h_near,
   output bas_pkg::bas_hpair_type h_cur,
   output bas_pkg::bas_sample_type centre_im
);
   import bas_pkg::*;

   // [row][age]: row 0 far, 1 near, 2 current; age 0 is one column back
   bas_pair_type win_ff [3][2];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0][1] <= win_ff[0][0];
         win_ff[0][0] <= far_tap;
         win_ff[1][1] <= win_ff[1][0];
         win_ff[1][0] <= near_tap;
         win_ff[2][1] <= win_ff[2][0];
         win_ff[2][0] <= cur;
      end
   end

   always_comb begin
      h_far.re  = hsum(win_ff[0][1].re, win_ff[0][0].re, far_tap.re);
      h_far.im  = hsum(win_ff[0][1].im, win_ff[0][0].im, far_tap.im);
      h_near.re = hsum(win_ff[1][1].re, win_ff[1][0].re, near_tap.re);
      h_near.im = hsum(win_ff[1][1].im, win_ff[1][0].im, near_tap.im);
      h_cur.re  = hsum(win_ff[2][1].re, win_ff[2][0].re, cur.re);
      h_cur.im  = hsum(win_ff[2][1].im, win_ff[2][0].im, cur.im);
   end

   assign centre_im = win_ff[1][0].im;

endmodule

// File: rtl/bas_calc.sv
// ----------------------------------------------------------------------------
// bas_calc: vertical combine and output register
// Two elastic stages: partial sums, then the weighted, shifted result.
// ----------------------------------------------------------------------------
module bas_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bas_pkg::bas_stage_type in_data,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bas_pkg::bas_rsp_type   rsp_data
);
   import bas_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   bas_stage_type s1_ff;
   logic          out_valid_ff, out_valid_in;
   bas_rsp_type   out_ff, out_in;
   logic          s2_ready;
   logic          s1_ready;

   bas_vsum_type  body_re, body_im, axis_re, axis_im;
   bas_vsum_type  sh_re, sh_im;

   assign s2_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      body_re = VSUM_W'(s1_ff.h_far.re) + (VSUM_W'(s1_ff.h_near.re) <<< 1)
              + VSUM_W'(s1_ff.h_cur.re);
      body_im = VSUM_W'(s1_ff.h_far.im) + (VSUM_W'(s1_ff.h_near.im) <<< 1)
              + VSUM_W'(s1_ff.h_cur.im);
      axis_re = VSUM_W'(s1_ff.h_near.re)
              + (s1_ff.mode_zero ? VSUM_W'(s1_ff.h_cur.re) : '0);
      axis_im = VSUM_W'(s1_ff.h_near.im);
      sh_re   = s1_ff.axis ? (axis_re >>> AXIS_SHIFT) : (body_re >>> BODY_SHIFT);
      sh_im   = s1_ff.axis ? (axis_im >>> AXIS_SHIFT) : (body_im >>> BODY_SHIFT);

      out_in.smooth_re = sh_re[SAMPLE_W-1:0];
      out_in.smooth_im = s1_ff.mode_zero ? s1_ff.centre_im : sh_im[SAMPLE_W-1:0];
      out_in.cell_col  = s1_ff.col;
      out_in.cell_row  = s1_ff.row;
      out_in.tile_done = s1_ff.done;
   end

   always_comb begin
      s1_valid_in  = s1_ready ? in_valid : s1_valid_ff;
      out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_ff <= in_data;
      end
      if (s2_ready && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_rise_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a staged request");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && s1_valid_ff) |=> s1_valid_ff)
      else $error("staged request lost while output stalled");

endmodule

// File: rtl/binomial_3x3_axis_smoothing.sv
// ----------------------------------------------------------------------------
// binomial_3x3_axis_smoothing: 3x3 binomial smoothing over a streamed tile
// Pipeline: a result passes the partial sum stage, then the output stage, on
//   its way from the request that completes its window to the output register.
// Throughput: one request per cycle while req_stall is low; the line stores
//   are a chain of column cells that all shift once per accepted request.
// Reset: clears the counters, pipeline valids and sets mode_zero to 1;
//   line stores and window are not cleared.
// ----------------------------------------------------------------------------
module binomial_3x3_axis_smoothing #(
   parameter int TILE_COLS = bas_pkg::DEF_TILE_COLS,
   parameter int TILE_ROWS = bas_pkg::DEF_TILE_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bas_pkg::bas_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bas_pkg::bas_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import bas_pkg::*;

   localparam int ROW_LEN = TILE_COLS + 2;
   localparam int CW      = $clog2(ROW_LEN);
   localparam int RW      = $clog2(TILE_ROWS + 1);
   localparam int OCW     = (CW > COL_OUT_W) ? CW : COL_OUT_W;
   localparam int ORW     = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;

   logic          mode_zero_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          req_accept;
   logic          calc_ready;
   logic          produce;
   logic [OCW-1:0] ocol;
   logic [ORW-1:0] orow;

   bas_pair_type  cur;
   bas_pair_type  near_link [ROW_LEN+1];
   bas_pair_type  far_link  [ROW_LEN+1];
   bas_hpair_type  win_h_far, win_h_near, win_h_cur;
   bas_sample_type win_centre_im;
   bas_stage_type stage;

   assign req_stall  = !calc_ready;
   assign req_accept = req_valid && calc_ready;

   assign cur.re = req_data.sample_re;
   assign cur.im = req_data.sample_im;

   // line stores: near row feeds the far row at the end of the chain
   assign near_link[0] = cur;
   assign far_link[0]  = near_link[ROW_LEN];

   for (genvar k = 0; k < ROW_LEN; k++) begin : g_col
      bas_cell u_cell (
         .clock    (clock),
         .shift_en (req_accept),
         .near_in  (near_link[k]),
         .far_in   (far_link[k]),
         .near_out (near_link[k+1]),
         .far_out  (far_link[k+1])
      );
   end

   bas_window u_window (
      .clock     (clock),
      .shift_en  (req_accept),
      .cur       (cur),
      .near_tap  (near_link[ROW_LEN]),
      .far_tap   (far_link[ROW_LEN]),
      .h_far     (win_h_far),
      .h_near    (win_h_near),
      .h_cur     (win_h_cur),
      .centre_im (win_centre_im)
   );

   always_comb begin
      produce = (row_ff != '0) && (col_ff >= CW'(2));
      ocol    = OCW'(col_ff) - OCW'(2);
      orow    = ORW'(row_ff) - ORW'(1);

      stage.h_far     = win_h_far;
      stage.h_near    = win_h_near;
      stage.h_cur     = win_h_cur;
      stage.centre_im = win_centre_im;
      stage.axis      = (row_ff == RW'(1));
      stage.mode_zero = mode_zero_ff;
      stage.col       = ocol[COL_OUT_W-1:0];
      stage.row       = orow[ROW_OUT_W-1:0];
      stage.done      = (orow == ORW'(TILE_ROWS - 1)) && (ocol == OCW'(TILE_COLS - 1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (req_data.tile_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == CW'(ROW_LEN - 1)) begin
            col_in = '0;
            row_in = (row_ff == RW'(TILE_ROWS)) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_zero_ff <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_zero_ff <= csr_wr_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   bas_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept && produce),
      .in_data   (stage),
      .in_ready  (calc_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_reset_pos: assert property (@(posedge clock)
      reset |=> (col_ff == '0 && row_ff == '0))
      else $error("position not cleared by reset");

   a_tile_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.tile_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("tile end did not restart the position");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_data.tile_end && col_ff == CW'(ROW_LEN - 1))
      |=> (col_ff == '0))
      else $error("column did not wrap at end of row");

endmodule
